// ----- design/ct_rms_current_meter_assert.svh -----
// Assertion macros shared by the RMS current meter.
// Each macro takes a label, the clock, the reset, the condition(s) and a message.
`ifndef CT_RMS_CURRENT_METER_ASSERT_SVH
`define CT_RMS_CURRENT_METER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRM_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRM_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge outside reset.
`define CRM_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error(msg);

`endif

// ----- design/crm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crm_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 16;

  localparam int OFFSET_BITS   = 12;
  localparam int DEADBAND_BITS = 8;
  localparam int SCALE_BITS    = 24;
  localparam int WINDOW_BITS   = 16;
  localparam int VOLT_BITS     = 8;
  localparam int SUM_BITS      = 40;
  localparam int MA_BITS       = 16;
  localparam int POWER_BITS    = MA_BITS + VOLT_BITS;
  localparam int INDEX_BITS    = 16;
  localparam int FRAC_BITS     = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;

  // Magnitude of a centered sample covers both the sample and the offset range.
  localparam int DIFF_BITS     = (SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
  localparam int SQUARE_BITS   = 2 * DIFF_BITS;
  localparam int SQ_CNT_BITS   = $clog2(DIFF_BITS);
  localparam int WIN_CMP_BITS  = (WINDOW_BITS > COUNT_BITS) ? WINDOW_BITS : COUNT_BITS;

  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
  localparam int ROOT_BITS     = SUM_BITS / 2;
  localparam int REM_BITS      = ROOT_BITS + 2;
  localparam int SQRT_CNT_BITS = $clog2(ROOT_BITS);
  localparam int PROD_BITS     = ROOT_BITS + SCALE_BITS;
  localparam int SCL_CNT_BITS  = $clog2((ROOT_BITS > VOLT_BITS) ? ROOT_BITS : VOLT_BITS);

  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [OFFSET_BITS-1:0]   OFFSET_RESET   = 12'd2048;
  localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = 8'd4;
  localparam logic [SCALE_BITS-1:0]    SCALE_RESET    = 24'd960000;
  localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET   = 16'd1000;
  localparam logic [VOLT_BITS-1:0]     VOLT_RESET     = 8'd230;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ZERO_CODE      = 3'd0,
    CFG_DEADBAND_LIMIT = 3'd1,
    CFG_CURRENT_SCALE  = 3'd2,
    CFG_WINDOW_LENGTH  = 3'd3,
    CFG_VOLTAGE_RMS    = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [1:0] {
    ACC_IDLE,
    ACC_SQUARE,
    ACC_ADD
  } acc_state_t;

  typedef enum logic [2:0] {
    SCL_IDLE,
    SCL_SCALE,
    SCL_ROUND,
    SCL_POWER,
    SCL_HOLD
  } scl_state_t;

endpackage

`default_nettype wire

// ----- design/crm_accum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crm_accum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [crm_pkg::SAMPLE_BITS-1:0]   sample,
  input  logic [crm_pkg::OFFSET_BITS-1:0]   zero_code,
  input  logic [crm_pkg::DEADBAND_BITS-1:0] deadband_limit,
  input  logic [crm_pkg::WINDOW_BITS-1:0]   window_length,
  output crm_pkg::unit_stat_t               stat,
  output logic                              win_end,
  output logic [crm_pkg::SUM_BITS-1:0]      win_sum,
  output logic [crm_pkg::COUNT_BITS-1:0]    win_count
);
  import crm_pkg::*;

  acc_state_t               state, state_next;
  logic [DIFF_BITS-1:0]     mag;
  logic [SQUARE_BITS-1:0]   prod;
  logic [SQ_CNT_BITS-1:0]   step;
  logic [SUM_BITS-1:0]      square_sum;
  logic [COUNT_BITS-1:0]    samples_taken;
  logic                     done;

  logic [DIFF_BITS-1:0]     sample_ext, offset_ext, diff, mag_in;
  logic [DIFF_BITS:0]       partial;
  logic [SQUARE_BITS-1:0]   prod_step;
  logic [SUM_BITS:0]        sum_add;
  logic [SUM_BITS-1:0]      sum_sat;
  logic [COUNT_BITS-1:0]    count_inc;
  logic                     window_open;

  always_comb begin
    sample_ext = DIFF_BITS'(sample);
    offset_ext = DIFF_BITS'(zero_code);
    diff       = (sample_ext >= offset_ext) ? sample_ext - offset_ext : offset_ext - sample_ext;
    mag_in     = (diff < DIFF_BITS'(deadband_limit)) ? '0 : diff;

    // Shift-add squaring, one multiplier bit per cycle from the low end.
    partial   = {1'b0, prod[SQUARE_BITS-1:DIFF_BITS]} + (prod[0] ? {1'b0, mag} : '0);
    prod_step = {partial, prod[DIFF_BITS-1:1]};

    sum_add   = {1'b0, square_sum} + (SUM_BITS + 1)'(prod);
    sum_sat   = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];

    // The window stays open while the count is below the length and below the
    // counter limit; a length of zero closes it at once.
    count_inc   = samples_taken + 1'b1;
    window_open = (WIN_CMP_BITS'(count_inc) < WIN_CMP_BITS'(window_length)) &&
                  (count_inc != COUNT_MAX);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ACC_IDLE:   if (start) state_next = ACC_SQUARE;
      ACC_SQUARE: if (step == '0) state_next = ACC_ADD;
      ACC_ADD:    state_next = ACC_IDLE;
      default:    state_next = ACC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ACC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      samples_taken <= '0;
      done          <= 1'b0;
      win_end       <= 1'b0;
    end else begin
      done <= (state == ACC_ADD);
      unique case (state)
        ACC_IDLE: begin
          if (start) begin
            mag  <= mag_in;
            prod <= {{DIFF_BITS{1'b0}}, mag_in};
            step <= SQ_CNT_BITS'(DIFF_BITS - 1);
          end
        end
        ACC_SQUARE: begin
          prod <= prod_step;
          step <= step - 1'b1;
        end
        ACC_ADD: begin
          win_count <= count_inc;
          if (window_open) begin
            square_sum    <= sum_sat;
            samples_taken <= count_inc;
            win_end       <= 1'b0;
          end else begin
            win_sum       <= sum_sat;
            square_sum    <= '0;
            samples_taken <= '0;
            win_end       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.busy = (state != ACC_IDLE);
  assign stat.done = done;

endmodule

`default_nettype wire

// ----- design/crm_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crm_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [crm_pkg::SUM_BITS-1:0]   dividend,
  input  logic [crm_pkg::COUNT_BITS-1:0] divisor,
  output crm_pkg::unit_stat_t            stat,
  output logic [crm_pkg::SUM_BITS-1:0]   quotient
);
  import crm_pkg::*;

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] step;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   dvsr;
  logic [SUM_BITS-1:0]     quot;

  logic [COUNT_BITS:0]     shifted, diff;
  logic                    fits;

  // Restoring division: one quotient bit per cycle, most significant first.
  // The dividend shifts out of the top of quot while quotient bits enter below.
  always_comb begin
    shifted = {rem, quot[SUM_BITS-1]};
    diff    = shifted - {1'b0, dvsr};
    fits    = (shifted >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem  <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
        quot <= {quot[SUM_BITS-2:0], fits};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        dvsr <= divisor;
        quot <= dividend;
        step <= DIV_CNT_BITS'(SUM_BITS - 1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quot;

endmodule

`default_nettype wire

// ----- design/crm_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crm_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [crm_pkg::SUM_BITS-1:0]  radicand,
  output crm_pkg::unit_stat_t           stat,
  output logic [crm_pkg::ROOT_BITS-1:0] root
);
  import crm_pkg::*;

  logic                     busy;
  logic                     done;
  logic [SQRT_CNT_BITS-1:0] step;
  logic [SUM_BITS-1:0]      rad;
  logic [REM_BITS-1:0]      rem;
  logic [ROOT_BITS-1:0]     res;

  logic [REM_BITS-1:0]      shifted, trial;
  logic                     fits;

  // Digit-by-digit square root: two radicand bits come down per cycle and one
  // root bit is settled. The remainder never exceeds twice the partial root.
  always_comb begin
    shifted = {rem[ROOT_BITS-1:0], rad[SUM_BITS-1 -: 2]};
    trial   = {res, 2'b01};
    fits    = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem  <= fits ? shifted - trial : shifted;
        res  <= {res[ROOT_BITS-2:0], fits};
        rad  <= {rad[SUM_BITS-3:0], 2'b00};
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        res  <= '0;
        step <= SQRT_CNT_BITS'(ROOT_BITS - 1);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = res;

endmodule

`default_nettype wire

// ----- design/crm_scaler.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crm_scaler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            take,
  input  logic [crm_pkg::ROOT_BITS-1:0]   root,
  input  logic [crm_pkg::SCALE_BITS-1:0]  current_scale,
  input  logic [crm_pkg::VOLT_BITS-1:0]   voltage_rms,
  output crm_pkg::unit_stat_t             stat,
  output logic [crm_pkg::MA_BITS-1:0]     ma,
  output logic [crm_pkg::POWER_BITS-1:0]  power
);
  import crm_pkg::*;

  scl_state_t              state, state_next;
  logic [SCL_CNT_BITS-1:0] step;
  logic [PROD_BITS-1:0]    prod;
  logic [POWER_BITS-1:0]   pwr;
  logic [MA_BITS-1:0]      ma_reg;

  logic [SCALE_BITS:0]     partial;
  logic [PROD_BITS-1:0]    prod_step;
  logic [PROD_BITS-1:0]    rounded;
  logic [MA_BITS-1:0]      ma_round;
  logic [MA_BITS:0]        ppartial;
  logic [POWER_BITS-1:0]   pwr_step;

  always_comb begin
    // root times scale, one root bit per cycle from the low end
    partial   = {1'b0, prod[PROD_BITS-1:ROOT_BITS]} +
                (prod[0] ? {1'b0, current_scale} : '0);
    prod_step = {partial, prod[ROOT_BITS-1:1]};

    // Round half up out of Q28.16, then saturate to the milliamp range.
    rounded  = prod + (PROD_BITS'(1) << (FRAC_BITS - 1));
    ma_round = (|rounded[PROD_BITS-1:FRAC_BITS+MA_BITS]) ? '1
             : rounded[FRAC_BITS+MA_BITS-1:FRAC_BITS];

    // current times voltage, one voltage bit per cycle
    ppartial = {1'b0, pwr[POWER_BITS-1:VOLT_BITS]} + (pwr[0] ? {1'b0, ma_reg} : '0);
    pwr_step = {ppartial, pwr[VOLT_BITS-1:1]};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SCL_IDLE:  if (start) state_next = SCL_SCALE;
      SCL_SCALE: if (step == '0) state_next = SCL_ROUND;
      SCL_ROUND: state_next = SCL_POWER;
      SCL_POWER: if (step == '0) state_next = SCL_HOLD;
      SCL_HOLD:  if (take) state_next = SCL_IDLE;
      default:   state_next = SCL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SCL_IDLE: begin
        if (start) begin
          prod <= {{SCALE_BITS{1'b0}}, root};
          step <= SCL_CNT_BITS'(ROOT_BITS - 1);
        end
      end
      SCL_SCALE: begin
        prod <= prod_step;
        step <= step - 1'b1;
      end
      SCL_ROUND: begin
        ma_reg <= ma_round;
        pwr    <= {{MA_BITS{1'b0}}, voltage_rms};
        step   <= SCL_CNT_BITS'(VOLT_BITS - 1);
      end
      SCL_POWER: begin
        pwr  <= pwr_step;
        step <= step - 1'b1;
      end
      SCL_HOLD: ;
      default: ;
    endcase
  end

  assign stat.busy = (state != SCL_IDLE);
  assign stat.done = (state == SCL_HOLD);
  assign ma        = ma_reg;
  assign power     = pwr;

endmodule

`default_nettype wire

// ----- design/ct_rms_current_meter.sv -----
// RMS current meter for a current-transformer input.
// Samples enter on in_valid/in_ready with sample_code. Each request is centered,
// passed through the deadband and squared bit-serially into a 40-bit sum; a
// sample that does not close the window is done once the squaring shift-add
// over the sample magnitude has finished, and the next sample waits for that.
// The sample that closes a window starts the back end: a restoring divider,
// a digit-serial square root and a bit-serial scale and power multiply. With
// the output register free, a result request appears on out_valid when the
// scaler finishes, and in_ready returns with it; input stays blocked until
// the result has left the back end.
// Results carry rms_current_ma, apparent_power_mva and measurement_index and
// sit in an output register: while the receiver stalls, the meter keeps
// accepting samples until a later result waits in the scaler, and input then
// stays blocked until the output register frees.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is high outside reset. Write only while the meter is idle.
// Reset restores default register values, clears the sum, the sample count
// and the measurement counter, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "ct_rms_current_meter_assert.svh"

module ct_rms_current_meter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [crm_pkg::SAMPLE_BITS-1:0]    sample_code,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crm_pkg::MA_BITS-1:0]        rms_current_ma,
  output logic [crm_pkg::POWER_BITS-1:0]     apparent_power_mva,
  output logic [crm_pkg::INDEX_BITS-1:0]     measurement_index,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [crm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [crm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import crm_pkg::*;

  logic [OFFSET_BITS-1:0]   zero_code;
  logic [DEADBAND_BITS-1:0] deadband_limit;
  logic [SCALE_BITS-1:0]    current_scale;
  logic [WINDOW_BITS-1:0]   window_length;
  logic [VOLT_BITS-1:0]     voltage_rms;
  logic [INDEX_BITS-1:0]    windows_done;

  unit_stat_t            acc_stat, div_stat, sqrt_stat, scl_stat;
  logic                  acc_win_end;
  logic [SUM_BITS-1:0]   acc_sum;
  logic [COUNT_BITS-1:0] acc_count;
  logic [SUM_BITS-1:0]   mean;
  logic [ROOT_BITS-1:0]  root;
  logic [MA_BITS-1:0]    scl_ma;
  logic [POWER_BITS-1:0] scl_power;

  logic in_take;
  logic backend_idle;
  logic result_move;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_code      <= OFFSET_RESET;
      deadband_limit <= DEADBAND_RESET;
      current_scale  <= SCALE_RESET;
      window_length  <= WINDOW_RESET;
      voltage_rms    <= VOLT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ZERO_CODE:      zero_code      <= cfg_data[OFFSET_BITS-1:0];
        CFG_DEADBAND_LIMIT: deadband_limit <= cfg_data[DEADBAND_BITS-1:0];
        CFG_CURRENT_SCALE:  current_scale  <= cfg_data[SCALE_BITS-1:0];
        CFG_WINDOW_LENGTH:  window_length  <= cfg_data[WINDOW_BITS-1:0];
        CFG_VOLTAGE_RMS:    voltage_rms    <= cfg_data[VOLT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One sample at a time; a closing sample may only start once the back end
  // has handed its last result to the output register.
  assign backend_idle = !div_stat.busy && !div_stat.done &&
                        !sqrt_stat.busy && !sqrt_stat.done && !scl_stat.busy;
  assign in_ready     = !rst && !acc_stat.busy && !acc_stat.done && backend_idle;
  assign in_take      = in_valid && in_ready;
  assign result_move  = scl_stat.done && (!out_valid || out_ready);

  crm_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .start          (in_take),
    .sample         (sample_code),
    .zero_code      (zero_code),
    .deadband_limit (deadband_limit),
    .window_length  (window_length),
    .stat           (acc_stat),
    .win_end        (acc_win_end),
    .win_sum        (acc_sum),
    .win_count      (acc_count)
  );

  crm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (acc_stat.done && acc_win_end),
    .dividend (acc_sum),
    .divisor  (acc_count),
    .stat     (div_stat),
    .quotient (mean)
  );

  crm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (div_stat.done),
    .radicand (mean),
    .stat     (sqrt_stat),
    .root     (root)
  );

  crm_scaler u_scaler (
    .clk           (clk),
    .rst           (rst),
    .start         (sqrt_stat.done),
    .take          (result_move),
    .root          (root),
    .current_scale (current_scale),
    .voltage_rms   (voltage_rms),
    .stat          (scl_stat),
    .ma            (scl_ma),
    .power         (scl_power)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      windows_done <= '0;
    end else begin
      if (result_move) begin
        out_valid          <= 1'b1;
        rms_current_ma     <= scl_ma;
        apparent_power_mva <= scl_power;
        measurement_index  <= windows_done;
        windows_done       <= windows_done + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CRM_ASSERT_IMP(a_accept_backend_idle, clk, rst, in_valid && in_ready, !div_stat.busy && !sqrt_stat.busy && !scl_stat.busy, "sample accepted while back end busy")
  `CRM_ASSERT_ALWAYS(a_single_done, clk, rst, $onehot0({acc_stat.done, div_stat.done, sqrt_stat.done}), "two units finished together")
  `CRM_ASSERT_NXT(a_result_held, clk, rst, scl_stat.done && out_valid && !out_ready, scl_stat.done, "result dropped while output stalled")

endmodule

`default_nettype wire

// ----- bench/ct_rms_current_meter_tb.sv -----
`timescale 1ns / 1ps

module ct_rms_current_meter_tb;
  import crm_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int SETTLE_CYCLES   = 40;
  localparam int END_CYCLES      = 200;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int STALL_LIMIT     = 5000;
  localparam int RANDOM_SAMPLES  = 900;
  localparam int QUIET_TAIL      = 150;
  localparam int SAMPLE_TOP      = (1 << SAMPLE_BITS) - 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_UNUSED = 3'd5;

  typedef struct packed {
    logic [MA_BITS-1:0]    current_ma;
    logic [POWER_BITS-1:0] power_mva;
    logic [INDEX_BITS-1:0] window_number;
  } reading_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [SAMPLE_BITS-1:0]    sample_code;
  logic                      out_valid;
  logic                      out_ready;
  logic [MA_BITS-1:0]        rms_current_ma;
  logic [POWER_BITS-1:0]     apparent_power_mva;
  logic [INDEX_BITS-1:0]     measurement_index;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Predicted meter registers and state.
  logic [OFFSET_BITS-1:0]   p_offset;
  logic [DEADBAND_BITS-1:0] p_deadband;
  logic [SCALE_BITS-1:0]    p_scale;
  logic [WINDOW_BITS-1:0]   p_window;
  logic [VOLT_BITS-1:0]     p_volts;
  logic [SUM_BITS-1:0]      p_sum;
  logic [COUNT_BITS-1:0]    p_taken;
  logic [INDEX_BITS-1:0]    p_windows;
  reading_t                 pending_readings[$];

  int errors        = 0;
  int samples_in    = 0;
  int readings_seen = 0;
  int reg_writes    = 0;
  bit idle_enabled  = 1'b1;
  bit hold_off_request = 1'b0;

  ct_rms_current_meter dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .sample_code        (sample_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .rms_current_ma     (rms_current_ma),
    .apparent_power_mva (apparent_power_mva),
    .measurement_index  (measurement_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic logic [ROOT_BITS-1:0] floor_sqrt(input logic [SUM_BITS-1:0] v);
    logic [ROOT_BITS-1:0] root;
    logic [SUM_BITS-1:0]  trial;
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial = {{(SUM_BITS - ROOT_BITS){1'b0}}, root | (ROOT_BITS'(1) << b)};
      if (trial * trial <= v) root = trial[ROOT_BITS-1:0];
    end
    return root;
  endfunction

  // Adds one sample to the open window and queues a reading when it closes.
  task automatic accumulate_sample(input logic [SAMPLE_BITS-1:0] code);
    logic [DIFF_BITS-1:0]   mag;
    logic [SQUARE_BITS-1:0] sq;
    logic [SUM_BITS:0]      total;
    logic [COUNT_BITS:0]    count;
    logic [WINDOW_BITS-1:0] span;
    logic [SUM_BITS-1:0]    mean;
    logic [ROOT_BITS-1:0]   root;
    logic [PROD_BITS:0]     scaled;
    logic [MA_BITS-1:0]     ma;
    reading_t               r;
    mag = (code >= p_offset) ? code - p_offset : p_offset - code;
    if (mag < p_deadband) mag = '0;
    sq = SQUARE_BITS'(mag) * SQUARE_BITS'(mag);
    total = {1'b0, p_sum} + (SUM_BITS + 1)'(sq);
    p_sum = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
    span = (p_window == '0) ? WINDOW_BITS'(1) : p_window;
    count = {1'b0, p_taken} + (COUNT_BITS + 1)'(1);
    if (count < (COUNT_BITS + 1)'(span)) begin
      p_taken = count[COUNT_BITS-1:0];
    end else begin
      mean = p_sum / SUM_BITS'(count);
      root = floor_sqrt(mean);
      scaled = (PROD_BITS + 1)'(root) * (PROD_BITS + 1)'(p_scale) +
               (PROD_BITS + 1)'(1 << (FRAC_BITS - 1));
      ma = (|scaled[PROD_BITS:FRAC_BITS+MA_BITS]) ? '1 : scaled[FRAC_BITS +: MA_BITS];
      r.current_ma = ma;
      r.power_mva = POWER_BITS'(ma) * POWER_BITS'(p_volts);
      r.window_number = p_windows;
      pending_readings.push_back(r);
      p_windows++;
      p_sum = '0;
      p_taken = '0;
    end
  endtask

  // Follows every request on all three channels and checks each reading.
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      p_offset = OFFSET_RESET;
      p_deadband = DEADBAND_RESET;
      p_scale = SCALE_RESET;
      p_window = WINDOW_RESET;
      p_volts = VOLT_RESET;
      p_sum = '0;
      p_taken = '0;
      p_windows = '0;
      pending_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_ZERO_CODE:      p_offset = cfg_data[OFFSET_BITS-1:0];
          CFG_DEADBAND_LIMIT: p_deadband = cfg_data[DEADBAND_BITS-1:0];
          CFG_CURRENT_SCALE:  p_scale = cfg_data[SCALE_BITS-1:0];
          CFG_WINDOW_LENGTH:  p_window = cfg_data[WINDOW_BITS-1:0];
          CFG_VOLTAGE_RMS:    p_volts = cfg_data[VOLT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        samples_in++;
        accumulate_sample(sample_code);
      end
      if (out_valid && out_ready) begin
        if (pending_readings.size() == 0) begin
          errors++;
          $display("%0t ns: reading with no closed window: expected none, got %0d mA %0d mVA #%0d",
                   $time, rms_current_ma, apparent_power_mva, measurement_index);
        end else begin
          want = pending_readings.pop_front();
          readings_seen++;
          if (rms_current_ma !== want.current_ma) begin
            errors++;
            $display("%0t ns: rms_current_ma of window %0d: expected %0d, got %0d",
                     $time, want.window_number, want.current_ma, rms_current_ma);
          end
          if (apparent_power_mva !== want.power_mva) begin
            errors++;
            $display("%0t ns: apparent_power_mva of window %0d: expected %0d, got %0d",
                     $time, want.window_number, want.power_mva, apparent_power_mva);
          end
          if (measurement_index !== want.window_number) begin
            errors++;
            $display("%0t ns: measurement_index: expected %0d, got %0d",
                     $time, want.window_number, measurement_index);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no request moved for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Returns at the falling edge after acceptance with in_valid still high.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] code);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_code <= code;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] sel,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int delta;
    int value;
    case ($urandom_range(0, 3))
      0: return SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
      1: delta = int'(p_deadband) + int'($urandom_range(0, 2)) - 1;
      default: delta = int'($urandom_range(0, 600)) - 300;
    endcase
    if ($urandom_range(0, 1) == 0) delta = -delta;
    value = int'(p_offset) + delta;
    if (value < 0) value = 0;
    if (value > SAMPLE_TOP) value = SAMPLE_TOP;
    return value[SAMPLE_BITS-1:0];
  endfunction

  task automatic pick_random_setup();
    int centre;
    int v;
    logic [CFG_DATA_BITS-1:0] fill;
    fill = CFG_DATA_BITS'($urandom);
    case ($urandom_range(0, 5))
      0: centre = 0;
      1: centre = SAMPLE_TOP;
      default: centre = 1898 + $urandom_range(0, 300);
    endcase
    write_reg(CFG_ZERO_CODE, {fill[CFG_DATA_BITS-1:OFFSET_BITS], centre[OFFSET_BITS-1:0]});
    case ($urandom_range(0, 5))
      0: v = 255;
      1: v = $urandom_range(0, 255);
      default: v = $urandom_range(0, 24);
    endcase
    write_reg(CFG_DEADBAND_LIMIT, {fill[CFG_DATA_BITS-1:DEADBAND_BITS], v[DEADBAND_BITS-1:0]});
    case ($urandom_range(0, 7))
      0: v = (1 << SCALE_BITS) - 1;
      1: v = 0;
      2: v = $urandom_range(0, (1 << SCALE_BITS) - 1);
      default: v = $urandom_range(200000, 2000000);
    endcase
    write_reg(CFG_CURRENT_SCALE, v[SCALE_BITS-1:0]);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = $urandom_range(13, 64);
      default: v = $urandom_range(1, 12);
    endcase
    write_reg(CFG_WINDOW_LENGTH, {fill[CFG_DATA_BITS-1:WINDOW_BITS], v[WINDOW_BITS-1:0]});
    v = $urandom_range(0, 255);
    write_reg(CFG_VOLTAGE_RMS, {fill[CFG_DATA_BITS-1:VOLT_BITS], v[VOLT_BITS-1:0]});
  endtask

  // Default registers after reset; the default window is then cut short.
  task automatic check_reset_values();
    send_sample(12'd2048);
    send_sample(12'd2051);
    send_sample(12'd2052);
    wait_drained();
    write_reg(CFG_WINDOW_LENGTH, 24'h000001);
    send_sample(12'd4095);
    wait_drained();
  endtask

  task automatic check_field_extremes();
    write_reg(CFG_ZERO_CODE, 24'hFFF000);
    write_reg(CFG_DEADBAND_LIMIT, 24'hFFFF00);
    write_reg(CFG_CURRENT_SCALE, 24'hFFFFFF);
    write_reg(CFG_WINDOW_LENGTH, 24'hFF0001);
    write_reg(CFG_VOLTAGE_RMS, 24'h0000FF);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2048);
    wait_drained();
    write_reg(CFG_ZERO_CODE, 24'h000FFF);
    send_sample(12'd0);
    send_sample(12'd4095);
    wait_drained();
    write_reg(CFG_CURRENT_SCALE, 24'h000000);
    send_sample(12'd0);
    wait_drained();
    // Deadband edge: 254 away from the offset is zeroed, 255 is not.
    write_reg(CFG_ZERO_CODE, 24'hA58800);
    write_reg(CFG_DEADBAND_LIMIT, 24'h0000FF);
    write_reg(CFG_CURRENT_SCALE, 24'h0EA600);
    write_reg(CFG_VOLTAGE_RMS, 24'h000000);
    send_sample(12'd2302);
    send_sample(12'd2303);
    send_sample(12'd1793);
    wait_drained();
    // A window length of zero behaves as a single-sample window.
    write_reg(CFG_WINDOW_LENGTH, 24'h000000);
    write_reg(CFG_VOLTAGE_RMS, 24'h000001);
    send_sample(12'd2303);
    send_sample(12'd4095);
    wait_drained();
  endtask

  task automatic check_window_shortening();
    write_reg(CFG_DEADBAND_LIMIT, 24'h000000);
    write_reg(CFG_VOLTAGE_RMS, 24'h0000E6);
    write_reg(CFG_WINDOW_LENGTH, 24'h5AFFFF);
    repeat (5) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
    wait_drained();
    write_reg(CFG_WINDOW_LENGTH, 24'h000002);
    send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
    wait_drained();
  endtask

  task automatic check_ignored_writes();
    for (int k = CFG_FIRST_UNUSED; k < (1 << CFG_INDEX_BITS); k++)
      write_reg(CFG_INDEX_BITS'(k), CFG_DATA_BITS'($urandom));
    send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
    send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
    wait_drained();
  endtask

  // With one-sample windows the output side fills and the input must stall.
  task automatic check_output_backpressure();
    write_reg(CFG_WINDOW_LENGTH, 24'h000001);
    hold_off_request = 1'b1;
    repeat (10) send_sample(SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
    wait_drained();
  endtask

  task automatic run_random_traffic();
    int sent;
    int burst;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      wait_drained();
      if (sent >= RANDOM_SAMPLES - QUIET_TAIL) idle_enabled = 1'b0;
      pick_random_setup();
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        send_sample(pick_sample());
        sent++;
      end
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample_code = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    check_reset_values();
    check_field_extremes();
    check_window_shortening();
    check_ignored_writes();
    check_output_backpressure();
    run_random_traffic();
    repeat (END_CYCLES) @(negedge clk);
    $display("Checked %0d RMS readings from %0d ADC samples and %0d register writes,",
             readings_seen, samples_in, reg_writes);
    $display("including register extremes, shortened windows and a long output stall.");
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
